### rtl/double_ended_queue_core_assert.svh
// ----------------------------------------------------------------------------
// Deque core assertion macros
// Shared property wrappers for the double-ended queue checks.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_CORE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DQ_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/dq_pkg.sv
// ----------------------------------------------------------------------------
// Deque package
// Types, sizes and codes shared by the double-ended queue modules.
// ----------------------------------------------------------------------------
package dq_pkg;

	// Storage geometry.
	localparam int DQ_DEPTH  = 64;
	localparam int DQ_WIDTH  = 32;
	localparam int DQ_CNT_W  = $clog2(DQ_DEPTH + 1);
	localparam int DQ_LV     = (DQ_DEPTH > 1) ? $clog2(DQ_DEPTH) : 1;
	localparam int DQ_NL     = 1 << DQ_LV;
	localparam int DQ_WAIT_W = $clog2(DQ_LV + 1);

	// Operation codes.
	localparam logic [2:0] MODE_PUSH_FRONT = 3'd0;
	localparam logic [2:0] MODE_PUSH_BACK  = 3'd1;
	localparam logic [2:0] MODE_POP_FRONT  = 3'd2;
	localparam logic [2:0] MODE_POP_BACK   = 3'd3;
	localparam logic [2:0] MODE_PEEK_FRONT = 3'd4;
	localparam logic [2:0] MODE_PEEK_BACK  = 3'd5;

	// Status codes.
	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_EMPTY = 2'd1;
	localparam logic [1:0] STATUS_FULL  = 2'd2;

	// One operation beat.
	typedef struct packed {
		logic [2:0]                 mode;
		logic signed [DQ_WIDTH-1:0] push_word;
	} dq_in_t;

	// One result beat.
	typedef struct packed {
		logic signed [DQ_WIDTH-1:0] out_word;
		logic [1:0]                 status;
		logic [DQ_CNT_W-1:0]        occupancy;
	} dq_out_t;

	// Command broadcast to every cell of the chain.
	typedef struct packed {
		logic                shift_right;
		logic                shift_left;
		logic                write_back;
		logic [DQ_CNT_W-1:0] count;
		logic [DQ_WIDTH-1:0] push_word;
	} dq_cell_cmd_t;

endpackage

### rtl/dq_cell.sv
// ----------------------------------------------------------------------------
// Deque cell
// One word of the queue; shifts toward either neighbor or takes a new word.
// ----------------------------------------------------------------------------
module dq_cell
	import dq_pkg::*;
#(
	parameter int IDX = 0
) (
	input  logic                clk,
	input  dq_cell_cmd_t        cmd,
	input  logic [DQ_WIDTH-1:0] left_word,
	input  logic [DQ_WIDTH-1:0] right_word,
	output logic [DQ_WIDTH-1:0] word,
	output logic [DQ_WIDTH-1:0] leaf_word
);

	logic [DQ_WIDTH-1:0] data_q;
	logic                is_back;
	logic                is_slot;

	// The back word sits in the cell just below the count; the next free slot at the count.
	assign is_back = (cmd.count == DQ_CNT_W'(IDX + 1));
	assign is_slot = (cmd.count == DQ_CNT_W'(IDX));

	// Word storage: shift in from a neighbor or capture a push at the back.
	always_ff @(posedge clk) begin
		if (cmd.shift_right) begin
			data_q <= left_word;
		end else if (cmd.shift_left) begin
			data_q <= right_word;
		end else if (cmd.write_back && is_slot) begin
			data_q <= cmd.push_word;
		end
	end

	assign word      = data_q;
	assign leaf_word = data_q & {DQ_WIDTH{is_back}};

endmodule

### rtl/dq_sel_tree.sv
// ----------------------------------------------------------------------------
// Deque select tree
// Registered OR tree that gathers the one gated back word from the cells.
// ----------------------------------------------------------------------------
module dq_sel_tree #(
	parameter int W  = 32,
	parameter int LV = 6
) (
	input  logic                      clk,
	input  logic [(1<<LV)-1:0][W-1:0] leaves,
	output logic [W-1:0]              root
);

	localparam int NL = 1 << LV;
	localparam int NI = NL - 1;

	logic [W-1:0] node_q [NI];

	// Heap-ordered nodes, one register level per tree level.
	for (genvar k = 0; k < NI; k++) begin : g_node
		logic [W-1:0] lhs;
		logic [W-1:0] rhs;

		if (2 * k + 1 >= NI) begin : g_leaf
			assign lhs = leaves[2 * k + 1 - NI];
			assign rhs = leaves[2 * k + 2 - NI];
		end else begin : g_inner
			assign lhs = node_q[2 * k + 1];
			assign rhs = node_q[2 * k + 2];
		end

		always_ff @(posedge clk) begin
			node_q[k] <= lhs | rhs;
		end
	end

	assign root = node_q[0];

endmodule

### rtl/double_ended_queue_core.sv
// ----------------------------------------------------------------------------
// Double-ended queue core
// Pushes and front reads: result valid in the cycle after acceptance, one beat
// per cycle unless the receiver stalls. Back reads: new beats stall while the
// registered select tree over the cell chain gathers the back word.
// Reset: asynchronous, leaves the queue empty at once; no clearing pass.
// ----------------------------------------------------------------------------
`include "double_ended_queue_core_assert.svh"

module double_ended_queue_core
	import dq_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    cmd_valid,
	output logic    cmd_stall,
	input  dq_in_t  cmd,
	output logic    rsp_valid,
	input  logic    rsp_stall,
	output dq_out_t rsp
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_WAIT = 2'b10
	} dq_state_t;

	dq_state_t             state_q, state_d;
	logic [DQ_CNT_W-1:0]   word_count_q, count_d;
	logic [DQ_WAIT_W-1:0]  wait_cnt_q, wait_d;
	logic                  pop_back_q, pop_back_d;
	dq_out_t               rsp_q, rsp_d;
	logic                  rsp_valid_q;
	logic                  rsp_load;
	logic                  out_free;
	logic                  accept;
	logic                  is_full;
	logic                  is_empty;
	dq_cell_cmd_t          cell_cmd;
	logic [DQ_WIDTH-1:0]   cell_word [DQ_DEPTH];
	logic [DQ_NL-1:0][DQ_WIDTH-1:0] leaves;
	logic [DQ_WIDTH-1:0]   back_word;

	// Handshake.
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign cmd_stall = !((state_q == ST_IDLE) && out_free);
	assign accept    = cmd_valid && !cmd_stall;
	assign is_full   = (word_count_q == DQ_CNT_W'(DQ_DEPTH));
	assign is_empty  = (word_count_q == '0);

	// Cell chain: the front word lives in cell zero.
	for (genvar i = 0; i < DQ_DEPTH; i++) begin : g_cell
		logic [DQ_WIDTH-1:0] left_word;
		logic [DQ_WIDTH-1:0] right_word;

		if (i == 0) begin : g_first
			assign left_word = cell_cmd.push_word;
		end else begin : g_mid_l
			assign left_word = cell_word[i - 1];
		end

		if (i == DQ_DEPTH - 1) begin : g_last
			assign right_word = cell_word[i];
		end else begin : g_mid_r
			assign right_word = cell_word[i + 1];
		end

		dq_cell #(
			.IDX (i)
		) u_cell (
			.clk        (clk),
			.cmd        (cell_cmd),
			.left_word  (left_word),
			.right_word (right_word),
			.word       (cell_word[i]),
			.leaf_word  (leaves[i])
		);
	end

	// Unused tree inputs read as zero.
	for (genvar j = DQ_DEPTH; j < DQ_NL; j++) begin : g_pad
		assign leaves[j] = '0;
	end

	dq_sel_tree #(
		.W  (DQ_WIDTH),
		.LV (DQ_LV)
	) u_sel_tree (
		.clk    (clk),
		.leaves (leaves),
		.root   (back_word)
	);

	// Operation decode and sequencing.
	always_comb begin
		state_d              = state_q;
		count_d              = word_count_q;
		wait_d               = wait_cnt_q;
		pop_back_d           = pop_back_q;
		rsp_load             = 1'b0;
		rsp_d                = '0;
		cell_cmd             = '0;
		cell_cmd.count       = word_count_q;
		cell_cmd.push_word   = cmd.push_word;

		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					rsp_load = 1'b1;
					case (cmd.mode)
						MODE_PUSH_FRONT: begin
							if (is_full) begin
								rsp_d.status = STATUS_FULL;
							end else begin
								cell_cmd.shift_right = 1'b1;
								count_d = word_count_q + DQ_CNT_W'(1);
							end
						end
						MODE_PUSH_BACK: begin
							if (is_full) begin
								rsp_d.status = STATUS_FULL;
							end else begin
								cell_cmd.write_back = 1'b1;
								count_d = word_count_q + DQ_CNT_W'(1);
							end
						end
						MODE_POP_FRONT: begin
							if (is_empty) begin
								rsp_d.status = STATUS_EMPTY;
							end else begin
								rsp_d.out_word = cell_word[0];
								cell_cmd.shift_left = 1'b1;
								count_d = word_count_q - DQ_CNT_W'(1);
							end
						end
						MODE_PEEK_FRONT: begin
							if (is_empty) begin
								rsp_d.status = STATUS_EMPTY;
							end else begin
								rsp_d.out_word = cell_word[0];
							end
						end
						MODE_POP_BACK, MODE_PEEK_BACK: begin
							if (is_empty) begin
								rsp_d.status = STATUS_EMPTY;
							end else begin
								// Wait for the select tree to gather the back word.
								rsp_load   = 1'b0;
								state_d    = ST_WAIT;
								wait_d     = '0;
								pop_back_d = (cmd.mode == MODE_POP_BACK);
							end
						end
						default: begin
						end
					endcase
				end
			end
			ST_WAIT: begin
				if (wait_cnt_q == DQ_WAIT_W'(DQ_LV)) begin
					if (out_free) begin
						rsp_load       = 1'b1;
						rsp_d.out_word = back_word;
						if (pop_back_q) begin
							count_d = word_count_q - DQ_CNT_W'(1);
						end
						state_d = ST_IDLE;
					end
				end else begin
					wait_d = wait_cnt_q + DQ_WAIT_W'(1);
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		rsp_d.occupancy = count_d;
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			word_count_q <= '0;
			wait_cnt_q   <= '0;
			pop_back_q   <= 1'b0;
			rsp_valid_q  <= 1'b0;
		end else begin
			state_q      <= state_d;
			word_count_q <= count_d;
			wait_cnt_q   <= wait_d;
			pop_back_q   <= pop_back_d;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Checks.
	`DQ_ASSERT_NOW(a_count_range, 1'b1, word_count_q <= DQ_CNT_W'(DQ_DEPTH), "count above depth")
	`DQ_ASSERT_NOW(a_wait_stalls, state_q == ST_WAIT, cmd_stall, "beat taken during back read")
	`DQ_ASSERT_NEXT(a_push_grows, accept && !is_full && (cmd.mode == MODE_PUSH_FRONT || cmd.mode == MODE_PUSH_BACK), word_count_q == $past(word_count_q) + DQ_CNT_W'(1), "push did not grow count")
	`DQ_ASSERT_NOW(a_full_zero, rsp_valid_q && rsp_q.status == STATUS_FULL, rsp_q.out_word == '0, "refused push carries a word")

endmodule

### verif/double_ended_queue_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double-ended queue core testbench
// Drives push, pop and peek beats at both ends, including the empty and full
// corner cases and the two spare mode codes. A scoreboard keeps its own copy
// of the ring, predicts each result beat and compares it field by field,
// while sender idling and receiver stalls vary from phase to phase.
// ----------------------------------------------------------------------------
module double_ended_queue_core_test;
	import dq_pkg::*;

	// Mode codes that the core treats as no operation.
	localparam logic [2:0] MODE_SPARE_A = 3'd6;
	localparam logic [2:0] MODE_SPARE_B = 3'd7;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int OPS_PER_PHASE = 100;
	localparam int TAIL_CYCLES  = 4 * (DQ_LV + 2);

	// Keeps a copy of the ring and the expected result beats in order.
	class deque_result_checker;
		logic signed [DQ_WIDTH-1:0] ring [DQ_DEPTH];
		int                         head;
		int                         held;
		dq_out_t                    expected_results [$];
		int unsigned                mismatch_count;

		function new();
			head = 0;
			held = 0;
			mismatch_count = 0;
		endfunction

		function int pending();
			return expected_results.size();
		endfunction

		// Applies one accepted operation and queues the result it must give.
		function void accept_op(dq_in_t op);
			dq_out_t res;
			int      tail;
			res = '0;
			res.status = STATUS_OK;
			case (op.mode)
				MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
					if (held == DQ_DEPTH) begin
						res.status = STATUS_FULL;
					end else if (op.mode == MODE_PUSH_FRONT) begin
						head = (head + DQ_DEPTH - 1) % DQ_DEPTH;
						ring[head] = op.push_word;
						held++;
					end else begin
						ring[(head + held) % DQ_DEPTH] = op.push_word;
						held++;
					end
				end
				MODE_POP_FRONT, MODE_PEEK_FRONT: begin
					if (held == 0) begin
						res.status = STATUS_EMPTY;
					end else begin
						res.out_word = ring[head];
						if (op.mode == MODE_POP_FRONT) begin
							head = (head + 1) % DQ_DEPTH;
							held--;
						end
					end
				end
				MODE_POP_BACK, MODE_PEEK_BACK: begin
					if (held == 0) begin
						res.status = STATUS_EMPTY;
					end else begin
						tail = (head + held - 1) % DQ_DEPTH;
						res.out_word = ring[tail];
						if (op.mode == MODE_POP_BACK) begin
							held--;
						end
					end
				end
				default: begin
				end
			endcase
			res.occupancy = DQ_CNT_W'(held);
			expected_results.push_back(res);
		endfunction

		task report(string msg);
			$display("ERROR at %0t: %s", $realtime, msg);
			mismatch_count++;
		endtask

		// Compares one accepted result beat with the oldest expectation.
		task check_result(dq_out_t got);
			dq_out_t want;
			if (expected_results.size() == 0) begin
				report($sformatf("result beat with nothing expected: word %0d status %0d occ %0d",
					got.out_word, got.status, got.occupancy));
				return;
			end
			want = expected_results.pop_front();
			if (got.out_word !== want.out_word) begin
				report($sformatf("out_word %0d, expected %0d", got.out_word, want.out_word));
			end
			if (got.status !== want.status) begin
				report($sformatf("status %0d, expected %0d", got.status, want.status));
			end
			if (got.occupancy !== want.occupancy) begin
				report($sformatf("occupancy %0d, expected %0d", got.occupancy, want.occupancy));
			end
		endtask
	endclass

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    cmd_valid = 1'b0;
	logic    cmd_stall;
	dq_in_t  cmd = '0;
	logic    rsp_valid;
	logic    rsp_stall = 1'b0;
	dq_out_t rsp;

	deque_result_checker checker_h = new();

	int idle_pct = 0;
	int stall_pct = 0;
	int useful_ops = 0;
	int cycles = 0;

	double_ended_queue_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Receiver stalls at random, changing only on the falling edge.
	always @(negedge clk) begin
		rsp_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	// Both handshakes are sampled at the rising edge; the cycle counter guards the run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end else if (arst_n) begin
			if (cmd_valid && cmd_stall === 1'b0) begin
				checker_h.accept_op(cmd);
			end
			if (rsp_valid === 1'b1 && !rsp_stall) begin
				checker_h.check_result(rsp);
			end
		end
	end

	function automatic dq_in_t make_op(input logic [2:0] m, input logic [DQ_WIDTH-1:0] w);
		dq_in_t op;
		op.mode = m;
		op.push_word = w;
		return op;
	endfunction

	// Mostly uniform words, with the extremes mixed in now and then.
	function automatic logic [DQ_WIDTH-1:0] pick_word();
		case ($urandom_range(0, 9))
			0: return {1'b1, {(DQ_WIDTH - 1){1'b0}}};
			1: return {1'b0, {(DQ_WIDTH - 1){1'b1}}};
			2: return '0;
			3: return '1;
			default: return DQ_WIDTH'($urandom);
		endcase
	endfunction

	// Offers one beat after a random idle gap and holds it until it is taken.
	task automatic send_op(input dq_in_t op);
		bit taken;
		while ($urandom_range(0, 99) < idle_pct) begin
			cmd_valid <= 1'b0;
			@(negedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= op;
		do begin
			@(posedge clk);
			taken = (cmd_stall === 1'b0);
			@(negedge clk);
		end while (!taken);
		if (op.mode <= MODE_PEEK_BACK) begin
			useful_ops++;
		end
	endtask

	// Drops valid and waits until every expected result beat has come back.
	task automatic drain_results();
		cmd_valid <= 1'b0;
		while (checker_h.pending() != 0) begin
			@(negedge clk);
		end
	endtask

	// One random sequence: a fill run, a drain run or a mixed run.
	task automatic run_sequence();
		int          kind;
		int          n;
		logic [2:0]  m;
		kind = $urandom_range(0, 3);
		if (kind == 0) begin
			n = $urandom_range(10, 72);
		end else if (kind == 1) begin
			n = $urandom_range(10, 72);
		end else begin
			n = $urandom_range(4, 24);
		end
		repeat (n) begin
			if (kind == 0) begin
				m = $urandom_range(0, 1) ? MODE_PUSH_BACK : MODE_PUSH_FRONT;
			end else if (kind == 1) begin
				case ($urandom_range(0, 5))
					0, 2: m = MODE_POP_FRONT;
					1, 3: m = MODE_POP_BACK;
					4: m = MODE_PEEK_FRONT;
					default: m = MODE_PEEK_BACK;
				endcase
			end else if ($urandom_range(0, 15) == 0) begin
				m = $urandom_range(0, 1) ? MODE_SPARE_B : MODE_SPARE_A;
			end else begin
				m = 3'($urandom_range(0, 5));
			end
			send_op(make_op(m, pick_word()));
		end
	endtask

	initial begin
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 52; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 52; end
				default: begin idle_pct = 28; stall_pct = 28; end
			endcase

			if (phase == 0) begin
				// Reads on an empty queue, then extreme words in at both ends.
				send_op(make_op(MODE_POP_FRONT, DQ_WIDTH'($urandom)));
				send_op(make_op(MODE_POP_BACK, DQ_WIDTH'($urandom)));
				send_op(make_op(MODE_PEEK_FRONT, DQ_WIDTH'($urandom)));
				send_op(make_op(MODE_PEEK_BACK, DQ_WIDTH'($urandom)));
				send_op(make_op(MODE_SPARE_B, DQ_WIDTH'($urandom)));
				send_op(make_op(MODE_PUSH_BACK, 32'h7fff_ffff));
				send_op(make_op(MODE_PUSH_FRONT, 32'h8000_0000));
				send_op(make_op(MODE_PEEK_FRONT, DQ_WIDTH'($urandom)));
				send_op(make_op(MODE_PEEK_BACK, DQ_WIDTH'($urandom)));
				send_op(make_op(MODE_PUSH_BACK, 32'h0000_0000));
				send_op(make_op(MODE_PUSH_FRONT, 32'hffff_ffff));
				send_op(make_op(MODE_PUSH_BACK, 32'h5555_5555));
				send_op(make_op(MODE_PUSH_FRONT, 32'haaaa_aaaa));
				send_op(make_op(MODE_SPARE_A, DQ_WIDTH'($urandom)));
				send_op(make_op(MODE_SPARE_B, DQ_WIDTH'($urandom)));
				send_op(make_op(MODE_POP_BACK, DQ_WIDTH'($urandom)));
				send_op(make_op(MODE_POP_FRONT, DQ_WIDTH'($urandom)));
				send_op(make_op(MODE_PEEK_BACK, DQ_WIDTH'($urandom)));
				send_op(make_op(MODE_PEEK_FRONT, DQ_WIDTH'($urandom)));
				send_op(make_op(MODE_POP_BACK, DQ_WIDTH'($urandom)));
				send_op(make_op(MODE_POP_FRONT, DQ_WIDTH'($urandom)));
				send_op(make_op(MODE_POP_BACK, DQ_WIDTH'($urandom)));
				send_op(make_op(MODE_POP_FRONT, DQ_WIDTH'($urandom)));
				send_op(make_op(MODE_POP_BACK, DQ_WIDTH'($urandom)));
				useful_ops = 0;
			end

			// Random sequences until this phase has its share of real operations.
			while (useful_ops < (phase + 1) * OPS_PER_PHASE) begin
				run_sequence();
			end

			// The sender holds off until the core has answered everything.
			drain_results();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (checker_h.pending() != 0) begin
			checker_h.report($sformatf("%0d result beats never arrived", checker_h.pending()));
		end
		if (checker_h.mismatch_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
